// ----- hw/rtl/manhattan_reach_cell_count_core_macros.svh -----
// Assertion macros used by the checker module of this block.
`ifndef MANHATTAN_REACH_CELL_COUNT_CORE_MACROS_SVH
`define MANHATTAN_REACH_CELL_COUNT_CORE_MACROS_SVH

// Clocked property with an active-low reset that disables the check.
`define MRCC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mrcc assertion failed");

// A transaction offered but not taken keeps its payload on the next cycle.
`define MRCC_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error("mrcc payload not held");

`endif

// ----- hw/rtl/mrcc_pkg.sv -----
package mrcc_pkg;

  localparam int unsigned MaxRows = 64;
  localparam int unsigned MaxCols = 64;
  localparam int unsigned Cells   = MaxRows * MaxCols;

  localparam int unsigned AddrW  = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned PosW   = $clog2(Cells + 1);
  localparam int unsigned RowW   = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned ColW   = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int unsigned DimW   = 7;
  localparam int unsigned DistW  = 7;
  localparam int unsigned CountW = 13;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  localparam logic [DistW-1:0]  DistSat      = 7'd127;
  localparam logic [DimW-1:0]   HeightReset  = 7'd64;
  localparam logic [DimW-1:0]   WidthReset   = 7'd64;
  localparam logic [DistW-1:0]  ReachReset   = 7'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEIGHT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_REACH  = 2'd2
  } mrcc_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FWD,
    ST_FWD_DRAIN,
    ST_BWD,
    ST_BWD_DRAIN,
    ST_EMIT
  } mrcc_state_e;

  typedef struct packed {
    logic load;
    logic start_fwd;
    logic start_bwd;
    logic issue;
    logic bwd;
    logic emit;
  } mrcc_cmd_t;

  typedef struct packed {
    logic issue_last;
  } mrcc_status_t;

  // Zero reads as one, anything above the maximum saturates.
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v,
                                              input int unsigned maxv);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (int'(v) > int'(maxv)) begin
      r = DimW'(maxv);
    end
    return r;
  endfunction

  // Neighbour plus one, saturated, against the current distance.
  function automatic logic [DistW-1:0] relax(input logic [DistW-1:0] cur,
                                             input logic [DistW-1:0] nb);
    logic [DistW:0] c;
    c = {1'b0, nb} + {{DistW{1'b0}}, 1'b1};
    if (c > {1'b0, DistSat}) begin
      c = {1'b0, DistSat};
    end
    return (c[DistW-1:0] < cur) ? c[DistW-1:0] : cur;
  endfunction

endpackage

// ----- hw/rtl/mrcc_if.sv -----
interface mrcc_cell_if;
  logic valid;
  logic ready;
  logic cell_set;
  logic last_cell;

  modport source (output valid, output cell_set, output last_cell, input ready);
  modport sink (input valid, input cell_set, input last_cell, output ready);
endinterface

interface mrcc_count_if;
  logic        valid;
  logic        ready;
  logic [12:0] covered_count;

  modport source (output valid, output covered_count, input ready);
  modport sink (input valid, input covered_count, output ready);
endinterface

// ----- hw/rtl/mrcc_ctrl.sv -----
module mrcc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  input  mrcc_pkg::mrcc_status_t status_i,
  output mrcc_pkg::mrcc_cmd_t    cmd_o
);
  import mrcc_pkg::*;

  mrcc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.start_fwd = 1'b1;
            state_d         = ST_FWD;
          end
        end
      end
      ST_FWD: begin
        cmd_o.issue = 1'b1;
        if (status_i.issue_last) begin
          state_d = ST_FWD_DRAIN;
        end
      end
      ST_FWD_DRAIN: begin
        // The last forward cell is written here, before the backward pass reads it.
        cmd_o.start_bwd = 1'b1;
        state_d         = ST_BWD;
      end
      ST_BWD: begin
        cmd_o.issue = 1'b1;
        cmd_o.bwd   = 1'b1;
        if (status_i.issue_last) begin
          state_d = ST_BWD_DRAIN;
        end
      end
      ST_BWD_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/mrcc_datapath.sv -----
module mrcc_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mrcc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mrcc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  mrcc_pkg::mrcc_cmd_t             cmd_i,
  input  logic                            cell_set_i,
  output mrcc_pkg::mrcc_status_t          status_o,
  output logic [mrcc_pkg::CountW-1:0]     count_o
);
  import mrcc_pkg::*;

  logic [DimW-1:0]  height_q, width_q;
  logic [DistW-1:0] reach_q;
  logic [DimW-1:0]  hdim, wdim;
  logic [PosW-1:0]  total;
  logic [RowW-1:0]  hlast;
  logic [ColW-1:0]  wlast;

  logic [PosW-1:0]  load_pos_q;
  logic             load_en;

  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [AddrW-1:0] nb_addr;

  logic             src_mem [Cells];
  logic [DistW-1:0] dist_mem [Cells];

  logic             v1_q, bwd1_q, far_ok_q, near_ok_q, src_ok_q, src_rd_q;
  logic [AddrW-1:0] waddr_q;
  logic [DistW-1:0] da_q, db_q, prev_q;
  logic [DistW-1:0] base, far_val, d1, d;
  logic             counted;

  logic [CountW-1:0] count_q, out_count_q;

  assign hdim  = eff_dim(height_q, MaxRows);
  assign wdim  = eff_dim(width_q, MaxCols);
  assign total = PosW'(hdim) * PosW'(wdim);
  assign hlast = RowW'(hdim - DimW'(1));
  assign wlast = ColW'(wdim - DimW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HeightReset;
      width_q  <= WidthReset;
      reach_q  <= ReachReset;
    end else if (cfg_we_i) begin
      unique case (mrcc_cfg_idx_e'(cfg_idx_i))
        CFG_HEIGHT: height_q <= DimW'(cfg_data_i);
        CFG_WIDTH:  width_q  <= DimW'(cfg_data_i);
        CFG_REACH:  reach_q  <= DistW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The fill count marks which source entries belong to the current grid;
  // anything at or beyond it reads as clear.
  assign load_en = cmd_i.load && (load_pos_q < total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
    end else if (cmd_i.emit) begin
      load_pos_q <= '0;
    end else if (load_en) begin
      load_pos_q <= load_pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      src_mem[load_pos_q[AddrW-1:0]] <= cell_set_i;
    end
    if (cmd_i.issue) begin
      src_rd_q <= src_mem[addr_q];
    end
  end

  // Raster position counters, forward or reverse.
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    addr_d = addr_q;
    priority if (cmd_i.start_fwd) begin
      row_d  = '0;
      col_d  = '0;
      addr_d = '0;
    end else if (cmd_i.start_bwd) begin
      row_d  = hlast;
      col_d  = wlast;
      addr_d = AddrW'(total - PosW'(1));
    end else if (cmd_i.issue && !cmd_i.bwd) begin
      addr_d = addr_q + AddrW'(1);
      if (col_q == wlast) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end else if (cmd_i.issue) begin
      addr_d = addr_q - AddrW'(1);
      if (col_q == '0) begin
        col_d = wlast;
        row_d = row_q - RowW'(1);
      end else begin
        col_d = col_q - ColW'(1);
      end
    end else begin
      addr_d = addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    col_q  <= col_d;
    addr_q <= addr_d;
  end

  assign status_o.issue_last = cmd_i.bwd ? ((row_q == '0) && (col_q == '0))
                                         : ((row_q == hlast) && (col_q == wlast));

  // The row above in the forward pass, the row below in the backward pass.
  assign nb_addr = cmd_i.bwd ? (addr_q + AddrW'(wdim)) : (addr_q - AddrW'(wdim));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      bwd1_q    <= cmd_i.bwd;
      far_ok_q  <= cmd_i.bwd ? (row_q != hlast) : (row_q != '0);
      near_ok_q <= cmd_i.bwd ? (col_q != wlast) : (col_q != '0);
      src_ok_q  <= PosW'(addr_q) < load_pos_q;
      waddr_q   <= addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      dist_mem[waddr_q] <= d;
    end
    if (cmd_i.issue) begin
      da_q <= dist_mem[addr_q];
      db_q <= dist_mem[nb_addr];
    end
  end

  // With single-column grids the vertical neighbour is the cell just
  // computed, which the memory cannot return yet.
  always_comb begin
    base    = bwd1_q ? da_q : ((src_ok_q && src_rd_q) ? '0 : DistSat);
    far_val = (wdim == DimW'(1)) ? prev_q : db_q;
    d1      = far_ok_q ? relax(base, far_val) : base;
    d       = near_ok_q ? relax(d1, prev_q) : d1;
    counted = bwd1_q && (d != DistSat) && (d <= reach_q);
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prev_q <= d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.start_fwd) begin
      count_q <= '0;
    end else if (v1_q && counted && (count_q != '1)) begin
      count_q <= count_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_count_q <= count_q;
    end
  end

  assign count_o = out_count_q;

endmodule

// ----- hw/rtl/manhattan_reach_cell_count_core.sv -----
// Cells load at one per cycle while the block is taking input.
// After the last-cell transaction the block runs a forward and a backward raster
// pass over the distance memory, one cell a cycle each, with a drain state after
// each pass, and then loads the result into the output register.
// The next grid may load while the result waits to be taken.
// Reset restores the default registers and empties the grid; no clearing pass.
module manhattan_reach_cell_count_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mrcc_cell_if.sink                     cell_i,
  mrcc_count_if.source                  count_o,
  input  logic                          cfg_we_i,
  input  logic [mrcc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mrcc_pkg::CfgDataW-1:0] cfg_data_i
);
  import mrcc_pkg::*;

  mrcc_cmd_t         cmd;
  mrcc_status_t      status;
  logic              in_ready;
  logic              out_valid;
  logic [CountW-1:0] count;

  mrcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cell_i.valid),
    .in_last_i   (cell_i.last_cell),
    .in_ready_o  (in_ready),
    .out_ready_i (count_o.ready),
    .out_valid_o (out_valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mrcc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .cell_set_i (cell_i.cell_set),
    .status_o   (status),
    .count_o    (count)
  );

  assign cell_i.ready          = in_ready;
  assign count_o.valid         = out_valid;
  assign count_o.covered_count = count;

endmodule

// ----- hw/rtl/mrcc_checker.sv -----
`include "manhattan_reach_cell_count_core_macros.svh"

module mrcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [12:0] out_count_i
);
  import mrcc_pkg::*;

  // The passes start as soon as the last cell is taken, so input stalls.
  `MRCC_ASSERT(a_last_stalls_input, clk_i, rst_ni, (in_valid_i && in_ready_i && in_last_i) |=> !in_ready_i)

  // A new result only appears once the passes have run, with input stalled.
  `MRCC_ASSERT(a_result_after_passes, clk_i, rst_ni, $rose(out_valid_i) |-> !$past(in_ready_i))

  // The count cannot exceed the number of cells in the largest grid.
  `MRCC_ASSERT(a_count_in_range, clk_i, rst_ni, out_valid_i |-> (out_count_i <= CountW'(Cells)))

  `MRCC_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_count_i)

endmodule

bind manhattan_reach_cell_count_core mrcc_checker u_mrcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cell_i.valid),
  .in_ready_i  (cell_i.ready),
  .in_last_i   (cell_i.last_cell),
  .out_valid_i (count_o.valid),
  .out_ready_i (count_o.ready),
  .out_count_i (count_o.covered_count)
);
